FILE: rtl/sdr_pkg.sv
// Shared types and constants for the sorted record duplicate removal block.
`timescale 1ns / 1ps
`default_nettype none
package sdr_pkg;

  localparam int WORD_W  = 64;
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 5;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [CFG_W-1:0]   cfg_t;

  localparam count_t COUNT_MAX = '1;
  localparam cfg_t   CFG_RESET = cfg_t'(1);

endpackage
`default_nettype wire

FILE: rtl/sdr_if.sv
// Valid/ready channel interfaces for record words in and verdicts out.
`timescale 1ns / 1ps
`default_nettype none
interface sdr_in_if;
  logic          valid;
  logic          ready;
  sdr_pkg::word_t line_word;
  logic          dataset_start;

  modport source (output valid, output line_word, output dataset_start, input ready);
  modport sink   (input valid, input line_word, input dataset_start, output ready);
endinterface

interface sdr_out_if;
  logic            valid;
  logic            ready;
  logic            is_unique;
  sdr_pkg::count_t unique_count;
  sdr_pkg::count_t removed_count;

  modport source (output valid, output is_unique, output unique_count,
                  output removed_count, input ready);
  modport sink   (input valid, input is_unique, input unique_count,
                  input removed_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/sdr_store.sv
// Two-half record store: both halves read at one word position, one half written.
`timescale 1ns / 1ps
`default_nettype none
module sdr_store #(
  parameter int MAX_WORDS = 16,
  parameter int PW        = 4
) (
  input  wire logic           clk,
  input  wire logic           rd_en,
  input  wire logic [PW-1:0]  rd_addr,
  output sdr_pkg::word_t      rd0_data,
  output sdr_pkg::word_t      rd1_data,
  input  wire logic           wr_en,
  input  wire logic           wr_half,
  input  wire logic [PW-1:0]  wr_addr,
  input  wire sdr_pkg::word_t wr_data
);

  sdr_pkg::word_t mem0 [MAX_WORDS];
  sdr_pkg::word_t mem1 [MAX_WORDS];
  sdr_pkg::word_t rd0_r;
  sdr_pkg::word_t rd1_r;

  always_ff @(posedge clk) begin
    if (wr_en && !wr_half) begin
      mem0[wr_addr] <= wr_data;
    end
    if (wr_en && wr_half) begin
      mem1[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd0_r <= mem0[rd_addr];
      rd1_r <= mem1[rd_addr];
    end
  end

  assign rd0_data = rd0_r;
  assign rd1_data = rd1_r;

endmodule
`default_nettype wire

FILE: rtl/sdr_judge.sv
// Compare stage: word compare against the kept record, record verdict and counts.
`timescale 1ns / 1ps
`default_nettype none
module sdr_judge #(
  parameter int PW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // stage entry from the address stage
  input  wire logic          s0_fire,
  input  wire sdr_pkg::word_t s0_word,
  input  wire logic [PW-1:0] s0_pos,
  input  wire logic          s0_start,
  input  wire logic          s0_last,
  output logic               s1_free,
  // store access
  input  wire sdr_pkg::word_t rd0_data,
  input  wire sdr_pkg::word_t rd1_data,
  output logic               wr_en,
  output logic               wr_half,
  output logic [PW-1:0]      wr_addr,
  output sdr_pkg::word_t     wr_data,
  // results
  sdr_out_if.source          out_ch
);

  logic            s1_valid_r;
  sdr_pkg::word_t  s1_word_r;
  logic [PW-1:0]   s1_pos_r;
  logic            s1_start_r;
  logic            s1_last_r;

  logic            fwd_valid_r;
  logic            fwd_half_r;
  logic [PW-1:0]   fwd_pos_r;
  sdr_pkg::word_t  fwd_data_r;

  logic            kept_half_r, kept_half_nxt;
  logic            have_prev_r, have_prev_nxt;
  logic            differs_r, differs_nxt;
  sdr_pkg::count_t kept_r, kept_nxt;
  sdr_pkg::count_t dropped_r, dropped_nxt;

  logic            out_valid_r;
  logic            out_unique_r;
  sdr_pkg::count_t out_kept_r;
  sdr_pkg::count_t out_dropped_r;

  logic            out_free;
  logic            s1_fire;
  logic            hp;
  logic            ds;
  sdr_pkg::count_t kt;
  sdr_pkg::count_t dt;
  sdr_pkg::word_t  kept_word;
  logic            ds_all;
  logic            unique_rec;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign s1_free  = !s1_valid_r || s1_fire;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= s0_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire) begin
      s1_word_r  <= s0_word;
      s1_pos_r   <= s0_pos;
      s1_start_r <= s0_start;
      s1_last_r  <= s0_last;
    end
  end

  // capture a write that lands in the same cycle as the read of the next word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (s0_fire) begin
      fwd_valid_r <= s1_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire) begin
      fwd_half_r <= wr_half;
      fwd_pos_r  <= wr_addr;
      fwd_data_r <= wr_data;
    end
  end

  always_comb begin
    hp = s1_start_r ? 1'b0 : have_prev_r;
    ds = s1_start_r ? 1'b0 : differs_r;
    kt = s1_start_r ? '0 : kept_r;
    dt = s1_start_r ? '0 : dropped_r;

    kept_word = kept_half_r ? rd1_data : rd0_data;
    if (fwd_valid_r && (fwd_half_r == kept_half_r) && (fwd_pos_r == s1_pos_r)) begin
      kept_word = fwd_data_r;
    end

    ds_all     = ds || (hp && (kept_word != s1_word_r));
    unique_rec = !hp || ds_all;

    kept_half_nxt = kept_half_r;
    have_prev_nxt = hp;
    differs_nxt   = ds_all;
    kept_nxt      = kt;
    dropped_nxt   = dt;
    if (s1_last_r) begin
      differs_nxt = 1'b0;
      if (unique_rec) begin
        kept_half_nxt = !kept_half_r;
        have_prev_nxt = 1'b1;
        kept_nxt      = (kt == sdr_pkg::COUNT_MAX) ? kt : kt + 1'b1;
      end else begin
        dropped_nxt   = (dt == sdr_pkg::COUNT_MAX) ? dt : dt + 1'b1;
      end
    end
  end

  assign wr_en   = s1_fire;
  assign wr_half = !kept_half_r;
  assign wr_addr = s1_pos_r;
  assign wr_data = s1_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_half_r <= 1'b0;
      have_prev_r <= 1'b0;
      differs_r   <= 1'b0;
      kept_r      <= '0;
      dropped_r   <= '0;
    end else if (s1_fire) begin
      kept_half_r <= kept_half_nxt;
      have_prev_r <= have_prev_nxt;
      differs_r   <= differs_nxt;
      kept_r      <= kept_nxt;
      dropped_r   <= dropped_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_unique_r  <= unique_rec;
      out_kept_r    <= kept_nxt;
      out_dropped_r <= dropped_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.is_unique     = out_unique_r;
  assign out_ch.unique_count  = out_kept_r;
  assign out_ch.removed_count = out_dropped_r;

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> out_valid_r)
    else $error("record end did not raise a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !(s1_fire && s1_last_r))
    else $error("held result overwritten");

  a_diff_needs_prev: assert property (@(posedge clk) disable iff (!rst_n)
    !have_prev_r |-> !differs_r)
    else $error("difference flagged with no kept record");

  a_flip_on_unique: assert property (@(posedge clk) disable iff (!rst_n)
    kept_half_r != $past(kept_half_r) |-> out_valid_r && out_unique_r)
    else $error("kept half changed without a unique record");

endmodule
`default_nettype wire

FILE: rtl/sorted_record_duplicate_removal.sv
// Top level: word position tracking, record store and compare stage.
//
// Usage: record words arrive on in_ch, one 64-bit word per transfer, records
// back to back; dataset_start marks the first word of a dataset and clears
// the counts. cfg_we/cfg_wdata set the record length in words (0 acts as 1,
// above MAX_WORDS acts as MAX_WORDS); write it only while the block is idle.
// One verdict per record leaves on out_ch: is_unique plus saturating kept
// and removed counts. The first record of a dataset is always kept.
// Throughput: one word per cycle, unless a held verdict stalls a record's
// last word; set by the single read port of each store half, which is read
// once per word at the word's position. The last word's transfer issues its
// read; the compare stage then loads the verdict into the output register.
// Reset: synchronous, active low; clears counts, position and the kept
// half pointer. Store contents are not cleared and need no clearing pass.
// Stall: while out_ch holds a verdict, words of the next record still flow;
// its last word waits in the compare stage and in_ch.ready drops until
// out_ch takes the held verdict.
`timescale 1ns / 1ps
`default_nettype none
module sorted_record_duplicate_removal #(
  parameter int MAX_WORDS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire sdr_pkg::cfg_t cfg_wdata,
  sdr_in_if.sink             in_ch,
  sdr_out_if.source          out_ch
);

  localparam int PW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int LB  = $clog2(MAX_WORDS + 1);
  localparam int LW  = ((LB > sdr_pkg::CFG_W) ? LB : sdr_pkg::CFG_W) + 1;

  sdr_pkg::cfg_t  cfg_r;
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [LW-1:0]  len;
  logic [LW-1:0]  cfg_ext;
  logic [LW-1:0]  pos_inc;
  logic [PW-1:0]  pos;
  logic           last;
  logic           s0_fire;
  logic           s1_free;

  sdr_pkg::word_t rd0_data;
  sdr_pkg::word_t rd1_data;
  logic           wr_en;
  logic           wr_half;
  logic [PW-1:0]  wr_addr;
  sdr_pkg::word_t wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= sdr_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_comb begin
    cfg_ext = LW'(cfg_r);
    if (cfg_r == '0) begin
      len = LW'(1);
    end else if (cfg_ext > LW'(MAX_WORDS)) begin
      len = LW'(MAX_WORDS);
    end else begin
      len = cfg_ext;
    end
    pos     = in_ch.dataset_start ? '0 : wp_r;
    pos_inc = LW'(pos) + LW'(1);
    last    = (pos_inc >= len);
    wp_nxt  = last ? '0 : PW'(pos_inc);
  end

  assign in_ch.ready = s1_free;
  assign s0_fire     = in_ch.valid && s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
    end else if (s0_fire) begin
      wp_r <= wp_nxt;
    end
  end

  sdr_store #(
    .MAX_WORDS (MAX_WORDS),
    .PW        (PW)
  ) u_store (
    .clk      (clk),
    .rd_en    (s0_fire),
    .rd_addr  (pos),
    .rd0_data (rd0_data),
    .rd1_data (rd1_data),
    .wr_en    (wr_en),
    .wr_half  (wr_half),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  sdr_judge #(
    .PW (PW)
  ) u_judge (
    .clk      (clk),
    .rst_n    (rst_n),
    .s0_fire  (s0_fire),
    .s0_word  (in_ch.line_word),
    .s0_pos   (pos),
    .s0_start (in_ch.dataset_start),
    .s0_last  (last),
    .s1_free  (s1_free),
    .rd0_data (rd0_data),
    .rd1_data (rd1_data),
    .wr_en    (wr_en),
    .wr_half  (wr_half),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire
